// ===== hw/rtl/ble_pkg.sv =====
// Package: widths, codes and shared types of the bounded array list engine.
package ble_pkg;

    localparam int CAPACITY = 16;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int FUNC_W   = 4;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;
    localparam int STAT_W   = 2;

    typedef enum logic [FUNC_W-1:0] {
        OP_PUSH_BACK = 4'd0,
        OP_POP_BACK  = 4'd1,
        OP_READ      = 4'd2,
        OP_WRITE     = 4'd3,
        OP_INSERT    = 4'd4,
        OP_ERASE     = 4'd5,
        OP_FRONT     = 4'd6,
        OP_BACK      = 4'd7,
        OP_RESIZE    = 4'd8,
        OP_CLEAR     = 4'd9
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SHIFT,
        S_PUT,
        S_FILL,
        S_RDWAIT,
        S_POST
    } state_t;

    // write data source for the element store
    typedef enum logic [1:0] {
        WSEL_DATA,
        WSEL_MOVE,
        WSEL_ZERO
    } wsel_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        wsel_t             wsel;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic               valid;
        logic [DATA_W-1:0]  value;
        logic [CNT_W-1:0]   total;
        status_t            status;
    } res_t;

endpackage

// ===== hw/rtl/ble_if.sv =====
// Interfaces: request and response channels of the bounded array list engine.
interface ble_req_if;
    import ble_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] data_value;

    modport source (output valid, output func, output position, output data_value,
                    input ready);
    modport sink   (input valid, input func, input position, input data_value,
                    output ready);
endinterface

interface ble_rsp_if;
    import ble_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]         item_total;
    logic [STAT_W-1:0]        status;

    modport source (output valid, output read_value, output item_total, output status,
                    input ready);
    modport sink   (input valid, input read_value, input item_total, input status,
                    output ready);
endinterface

// ===== hw/rtl/ble_store.sv =====
// Element store: single write port, single registered read port.
module ble_store (
    input  logic                             clk,
    input  ble_pkg::mem_req_t                req,
    input  logic signed [ble_pkg::DATA_W-1:0] wr_value,
    output logic signed [ble_pkg::DATA_W-1:0] rd_value
);
    import ble_pkg::*;

    logic signed [DATA_W-1:0] mem [CAPACITY];
    logic signed [DATA_W-1:0] rdata_reg;
    logic signed [DATA_W-1:0] wdata;

    always_comb
    begin
        case (req.wsel)
            WSEL_DATA: wdata = wr_value;
            WSEL_MOVE: wdata = rdata_reg;
            default:   wdata = '0;
        endcase
    end

    // read data only moves on a read, so a later move can still use it
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rd_value = rdata_reg;

endmodule

// ===== hw/rtl/ble_seq.sv =====
// Sequencer: request decode, shared index step/compare unit and count.
module ble_seq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [ble_pkg::FUNC_W-1:0]        func,
    input  logic [ble_pkg::POS_W-1:0]         position,
    input  logic signed [ble_pkg::DATA_W-1:0] data_value,
    input  logic                              out_free,
    input  logic signed [ble_pkg::DATA_W-1:0] rd_value,
    output logic                              in_ready,
    output ble_pkg::mem_req_t                 mem_req,
    output logic signed [ble_pkg::DATA_W-1:0] wr_value,
    output ble_pkg::res_t                     res
);
    import ble_pkg::*;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     wpend_reg, wpend_next;
    logic [ADDR_W-1:0]        waddr_reg, waddr_next;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic signed [DATA_W-1:0] res_value_reg, res_value_next;
    status_t                  res_status_reg, res_status_next;
    op_t                      func_reg;
    logic [POS_W-1:0]         pos_reg;
    logic signed [DATA_W-1:0] data_reg;

    // shared step unit: one +/-1 adder and one compare per cycle
    logic             step_down;
    logic [CNT_W-1:0] idx_step;
    logic             step_go;
    logic             pos_oob;

    assign step_down = (func_reg == OP_INSERT);
    assign idx_step  = step_down ? idx_reg - 1'b1 : idx_reg + 1'b1;
    assign pos_oob   = (CNT_W'(pos_reg) >= count_reg);

    always_comb
    begin
        case (func_reg)
            OP_INSERT: step_go = (idx_reg > CNT_W'(pos_reg));
            OP_ERASE:  step_go = (idx_step < count_reg);
            default:   step_go = (idx_reg < CNT_W'(pos_reg));
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (func_reg)
                    OP_READ:   state_next = pos_oob ? S_POST : S_RDWAIT;
                    OP_FRONT,
                    OP_BACK:   state_next = (count_reg == '0) ? S_POST : S_RDWAIT;
                    OP_INSERT: state_next = ((CNT_W'(pos_reg) > count_reg) ||
                                             (count_reg >= CAP_CNT)) ? S_POST : S_SHIFT;
                    OP_ERASE:  state_next = pos_oob ? S_POST : S_SHIFT;
                    OP_RESIZE: state_next = (CNT_W'(pos_reg) > CAP_CNT) ? S_POST : S_FILL;
                    default:   state_next = S_POST;
                endcase
            end
            S_SHIFT:
            begin
                if (!step_go)
                begin
                    state_next = (func_reg == OP_INSERT) ? S_PUT : S_POST;
                end
            end
            S_PUT:    state_next = S_POST;
            S_FILL:
            begin
                if (!step_go)
                begin
                    state_next = S_POST;
                end
            end
            S_RDWAIT: state_next = S_POST;
            S_POST:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // outputs and datapath next values
    always_comb
    begin
        in_ready        = 1'b0;
        mem_req         = '0;
        mem_req.wsel    = WSEL_DATA;
        count_next      = count_reg;
        wpend_next      = wpend_reg;
        waddr_next      = waddr_reg;
        idx_next        = idx_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_EXEC:
            begin
                res_value_next  = '0;
                res_status_next = STAT_OK;
                wpend_next      = 1'b0;
                case (func_reg)
                    OP_PUSH_BACK:
                    begin
                        if (count_reg >= CAP_CNT)
                        begin
                            res_status_next = STAT_FULL;
                        end
                        else
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = count_reg[ADDR_W-1:0];
                            count_next    = count_reg + 1'b1;
                        end
                    end
                    OP_POP_BACK:
                    begin
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                    OP_READ:
                    begin
                        if (pos_oob)
                        begin
                            res_status_next = STAT_RANGE;
                        end
                        else
                        begin
                            mem_req.re    = 1'b1;
                            mem_req.raddr = pos_reg[ADDR_W-1:0];
                        end
                    end
                    OP_WRITE:
                    begin
                        if (pos_oob)
                        begin
                            res_status_next = STAT_RANGE;
                        end
                        else
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = pos_reg[ADDR_W-1:0];
                        end
                    end
                    OP_INSERT:
                    begin
                        if (CNT_W'(pos_reg) > count_reg)
                        begin
                            res_status_next = STAT_RANGE;
                        end
                        else if (count_reg >= CAP_CNT)
                        begin
                            res_status_next = STAT_FULL;
                        end
                        idx_next = count_reg;
                    end
                    OP_ERASE:
                    begin
                        if (pos_oob)
                        begin
                            res_status_next = STAT_RANGE;
                        end
                        idx_next = CNT_W'(pos_reg);
                    end
                    OP_FRONT,
                    OP_BACK:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = STAT_RANGE;
                        end
                        else
                        begin
                            mem_req.re    = 1'b1;
                            mem_req.raddr = (func_reg == OP_FRONT) ? '0 :
                                            count_reg[ADDR_W-1:0] - 1'b1;
                        end
                    end
                    OP_RESIZE:
                    begin
                        if (CNT_W'(pos_reg) > CAP_CNT)
                        begin
                            res_status_next = STAT_FULL;
                        end
                        idx_next = count_reg;
                    end
                    OP_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SHIFT:
            begin
                // move the word read last cycle, fetch the next one
                if (wpend_reg)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = waddr_reg;
                    mem_req.wsel  = WSEL_MOVE;
                end
                if (step_go)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = idx_step[ADDR_W-1:0];
                    wpend_next    = 1'b1;
                    waddr_next    = idx_reg[ADDR_W-1:0];
                    idx_next      = idx_step;
                end
                else
                begin
                    wpend_next = 1'b0;
                    if (func_reg == OP_ERASE)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            S_PUT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = pos_reg[ADDR_W-1:0];
                count_next    = count_reg + 1'b1;
            end
            S_FILL:
            begin
                if (step_go)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = idx_reg[ADDR_W-1:0];
                    mem_req.wsel  = WSEL_ZERO;
                    idx_next      = idx_step;
                end
                else
                begin
                    count_next = CNT_W'(pos_reg);
                end
            end
            S_RDWAIT:
            begin
                res_value_next = rd_value;
            end
            default:
            begin
            end
        endcase
    end

    assign wr_value   = data_reg;
    assign res.valid  = (state_reg == S_POST) && out_free;
    assign res.value  = res_value_reg;
    assign res.total  = count_reg;
    assign res.status = res_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            wpend_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            wpend_reg <= wpend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= op_t'(func);
            pos_reg  <= position;
            data_reg <= data_value;
        end
        waddr_reg      <= waddr_next;
        idx_reg        <= idx_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
    end

endmodule

// ===== hw/rtl/bounded_array_list_engine.sv =====
// Top level: bounded array list engine with request/response channels.
//
// A fixed-capacity (16) ordered list of signed 32-bit elements with a live
// count. Each request word on req (func, position, data_value) yields exactly
// one response word on rsp (read_value, item_total, status); both channels
// move a word when valid and ready are high at a rising edge.
// One request is in flight at a time: req.ready is high only while the
// sequencer is idle. The element store has one write and one registered read
// port, and the sequencer steps an index through it with a single +/-1 unit.
// Steps from request to response valid:
//   push/pop/write/clear, unused codes and all error cases: execute, then post
//   read/front/back: execute, wait for the registered read, post
//   insert at position p: execute, shift loop down to p, put, post; erase: execute, shift loop, post
//   resize from n up to m: execute, fill loop (one zero written a cycle), post
// The next word is taken as a response goes valid.
// The response sits in an output register, so the sequencer can finish the
// next request while the receiver stalls; it then waits until that register
// is taken. Reset empties the list (count zero); store contents stay as they
// were and are never read before being written.
module bounded_array_list_engine (
    input  logic       clk,
    input  logic       rst_n,
    ble_req_if.sink    req,
    ble_rsp_if.source  rsp
);
    import ble_pkg::*;

    mem_req_t                 mem_req;
    logic signed [DATA_W-1:0] wr_value;
    logic signed [DATA_W-1:0] rd_value;
    res_t                     res;
    logic                     in_ready;
    logic                     accept;
    logic                     out_free;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_value_reg;
    logic [CNT_W-1:0]         out_total_reg;
    logic [STAT_W-1:0]        out_status_reg;

    assign accept   = req.valid && in_ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign req.ready = in_ready;

    ble_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .func       (req.func),
        .position   (req.position),
        .data_value (req.data_value),
        .out_free   (out_free),
        .rd_value   (rd_value),
        .in_ready   (in_ready),
        .mem_req    (mem_req),
        .wr_value   (wr_value),
        .res        (res)
    );

    ble_store u_store (
        .clk      (clk),
        .req      (mem_req),
        .wr_value (wr_value),
        .rd_value (rd_value)
    );

    // response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            out_value_reg  <= res.value;
            out_total_reg  <= res.total;
            out_status_reg <= res.status;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = out_value_reg;
    assign rsp.item_total = out_total_reg;
    assign rsp.status     = out_status_reg;

endmodule

// ===== tb/sv/ble_checker.sv =====
`timescale 1ns / 100ps
// Checker: mirrors the list engine, predicts each response word and compares it.
module ble_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    ble_req_if                        req,
    ble_rsp_if                        rsp,
    output int                        errors,
    output int                        waiting,
    output logic [ble_pkg::CNT_W-1:0] list_len
);
    import ble_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [CNT_W-1:0]  total;
        status_t           status;
    } answer_t;

    logic [DATA_W-1:0] elems [CAPACITY];
    logic [CNT_W-1:0]  count;
    answer_t           answers_q [$];

    // apply one request to the mirrored list and return the response it gives
    function automatic answer_t apply_request(input logic [FUNC_W-1:0] f,
                                              input logic [POS_W-1:0]  p,
                                              input logic [DATA_W-1:0] d);
        answer_t a;
        int      i;
        a.value  = '0;
        a.status = STAT_OK;
        case (f)
            OP_PUSH_BACK:
                if (count >= CAPACITY) a.status = STAT_FULL;
                else
                begin
                    elems[ADDR_W'(count)] = d;
                    count++;
                end
            OP_POP_BACK:
                if (count > 0) count--;
            OP_READ:
                if (p >= count) a.status = STAT_RANGE;
                else a.value = elems[ADDR_W'(p)];
            OP_WRITE:
                if (p >= count) a.status = STAT_RANGE;
                else elems[ADDR_W'(p)] = d;
            OP_INSERT:
                if (p > count) a.status = STAT_RANGE;
                else if (count >= CAPACITY) a.status = STAT_FULL;
                else
                begin
                    for (i = count; i > p; i--) elems[ADDR_W'(i)] = elems[ADDR_W'(i-1)];
                    elems[ADDR_W'(p)] = d;
                    count++;
                end
            OP_ERASE:
                if (p >= count) a.status = STAT_RANGE;
                else
                begin
                    for (i = p; i + 1 < count; i++) elems[ADDR_W'(i)] = elems[ADDR_W'(i+1)];
                    count--;
                end
            OP_FRONT:
                if (count == 0) a.status = STAT_RANGE;
                else a.value = elems[0];
            OP_BACK:
                if (count == 0) a.status = STAT_RANGE;
                else a.value = elems[ADDR_W'(count - 1'b1)];
            OP_RESIZE:
                if (p > CAPACITY) a.status = STAT_FULL;
                else
                begin
                    for (i = count; i < p; i++) elems[ADDR_W'(i)] = '0;
                    count = p;
                end
            OP_CLEAR:
                count = '0;
            default: ;
        endcase
        a.total = count;
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        answer_t want;
        if (!rst_n)
        begin
            errors = 0;
            count  = '0;
            for (int k = 0; k < CAPACITY; k++) elems[ADDR_W'(k)] = '0;
            answers_q.delete();
            waiting  <= 0;
            list_len <= '0;
        end
        else
        begin
            // response first: a word leaving now never belongs to a request taken now
            if (rsp.valid && rsp.ready)
            begin
                if (answers_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected response word: expected none, got value %0d total %0d status %0d",
                             $time, $signed(rsp.read_value), rsp.item_total, rsp.status);
                end
                else
                begin
                    want = answers_q.pop_front();
                    if (rsp.read_value !== want.value)
                    begin
                        errors++;
                        $display("%0t: read_value expected %0d got %0d",
                                 $time, $signed(want.value), $signed(rsp.read_value));
                    end
                    if (rsp.item_total !== want.total)
                    begin
                        errors++;
                        $display("%0t: item_total expected %0d got %0d",
                                 $time, want.total, rsp.item_total);
                    end
                    if (rsp.status !== want.status)
                    begin
                        errors++;
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, rsp.status);
                    end
                end
            end
            if (req.valid && req.ready)
                answers_q.push_back(apply_request(req.func, req.position, req.data_value));
            waiting  <= answers_q.size();
            list_len <= count;
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top: drives request words into the list engine and gives the verdict.
module tb_top;
    import ble_pkg::*;

    localparam int N_RANDOM = 700;
    // codes with no operation behind them; the engine must leave the list alone
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 4'd10;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 4'd15;
    localparam logic [DATA_W-1:0] DATA_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] DATA_MAX = 32'h7fff_ffff;

    logic             clk;
    logic             rst_n;
    logic             idling;   // random gaps on both channels when set
    int               errors;
    int               waiting;  // response words still owed by the engine
    logic [CNT_W-1:0] list_len; // predicted length, only used to steer positions

    ble_req_if req_bus ();
    ble_rsp_if rsp_bus ();

    bounded_array_list_engine u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    ble_checker u_chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_bus),
        .rsp      (rsp_bus),
        .errors   (errors),
        .waiting  (waiting),
        .list_len (list_len)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: stalls with a chance of about 29 in a hundred while idling is on
    always @(posedge clk)
        rsp_bus.ready <= idling ? ($urandom_range(99) >= 29) : 1'b1;

    // hard stop, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // present one word and hold it until taken; maybe leave a gap afterwards
    task automatic send_word(input logic [FUNC_W-1:0] f,
                             input logic [POS_W-1:0]  p,
                             input logic [DATA_W-1:0] d);
        req_bus.valid      <= 1'b1;
        req_bus.func       <= f;
        req_bus.position   <= p;
        req_bus.data_value <= d;
        @(posedge clk);
        while (!req_bus.ready) @(posedge clk);
        if (idling && $urandom_range(99) < 29)
        begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // hold off the sender until every owed response has come back
    task automatic drain();
        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
    endtask

    // one random word; positions lean towards legal ones for the current length
    task automatic send_random();
        int                roll;
        int                n;
        logic [FUNC_W-1:0] f;
        logic [POS_W-1:0]  p;
        logic [DATA_W-1:0] d;
        n    = list_len;
        roll = $urandom_range(99);
        if (roll < 16)      f = OP_PUSH_BACK;
        else if (roll < 25) f = OP_POP_BACK;
        else if (roll < 40) f = OP_READ;
        else if (roll < 52) f = OP_WRITE;
        else if (roll < 65) f = OP_INSERT;
        else if (roll < 78) f = OP_ERASE;
        else if (roll < 83) f = OP_FRONT;
        else if (roll < 88) f = OP_BACK;
        else if (roll < 95) f = OP_RESIZE;
        else if (roll < 98) f = OP_CLEAR;
        else                f = FUNC_W'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));

        if (f == OP_RESIZE)      p = POS_W'($urandom_range(0, CAPACITY));
        else if (f == OP_INSERT) p = POS_W'($urandom_range(0, n));
        else                     p = (n == 0) ? '0 : POS_W'($urandom_range(0, n - 1));
        // some noise: any position the field can carry
        if ($urandom_range(99) < 6) p = POS_W'($urandom_range(0, 31));

        case ($urandom_range(9))
            0:       d = DATA_MIN;
            1:       d = DATA_MAX;
            default: d = $urandom();
        endcase
        send_word(f, p, d);
    endtask

    initial
    begin
        rst_n              = 1'b0;
        idling             = 1'b1;
        req_bus.valid      = 1'b0;
        req_bus.func       = OP_CLEAR;
        req_bus.position   = '0;
        req_bus.data_value = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty-list corners first
        send_word(OP_POP_BACK, 5'd0, '0);          // pop on empty is a no-op
        send_word(OP_FRONT,    5'd0, '0);          // front/back on empty
        send_word(OP_BACK,     5'd0, '0);
        send_word(OP_READ,     5'd0, '0);          // index at the count
        send_word(OP_WRITE,    5'd0, DATA_MAX);
        send_word(OP_ERASE,    5'd0, '0);
        send_word(OP_INSERT,   5'd1, DATA_MAX);    // insert beyond the count
        // build a short list and move things about
        send_word(OP_INSERT,   5'd0, DATA_MIN);
        send_word(OP_PUSH_BACK, 5'd0, DATA_MAX);
        send_word(OP_PUSH_BACK, 5'd31, '1);
        send_word(OP_INSERT,   5'd1, '0);
        send_word(OP_WRITE,    5'd2, 32'h5a5a_a5a5);
        send_word(OP_FRONT,    5'd0, '0);
        send_word(OP_BACK,     5'd0, '0);
        send_word(OP_ERASE,    5'd1, '0);
        // grow to capacity with zero fill, then push against the limit
        send_word(OP_RESIZE,   5'd16, '0);
        send_word(OP_PUSH_BACK, 5'd0, DATA_MIN);
        send_word(OP_INSERT,   5'd3, DATA_MIN);    // legal position but full
        send_word(OP_INSERT,   5'd17, DATA_MIN);
        send_word(OP_RESIZE,   5'd17, '0);
        send_word(OP_RESIZE,   5'd31, '0);
        send_word(OP_READ,     5'd15, '0);
        send_word(OP_READ,     5'd16, '0);
        send_word(OP_ERASE,    5'd15, '0);
        send_word(FUNC_UNUSED_LO, 5'd3, DATA_MAX);
        send_word(FUNC_UNUSED_HI, 5'd0, DATA_MAX);
        send_word(OP_CLEAR,    5'd0, '0);
        drain();

        // random part; a stretch in the middle runs with no gaps at all
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == 250) idling = 1'b0;
            if (i == 400) idling = 1'b1;
            if (i % 150 == 149) drain();
            send_random();
        end

        drain();
        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
